// ===== hdl/midi_command_line_parser_core_macros.svh =====
// Assertion macros shared by the command line parser RTL.
`ifndef MIDI_COMMAND_LINE_PARSER_CORE_MACROS_SVH
`define MIDI_COMMAND_LINE_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCLP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mclp_pkg.sv =====
// Package with character codes and helper functions for the command line parser.
package mclp_pkg;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_UP_M = 8'h4D;
    localparam logic [7:0] CHAR_LO_M = 8'h6D;
    localparam logic [7:0] CHAR_UP_T = 8'h54;
    localparam logic [7:0] CHAR_LO_T = 8'h74;
    localparam logic [7:0] CHAR_UP_N = 8'h4E;
    localparam logic [7:0] CHAR_LO_N = 8'h6E;
    localparam logic [7:0] CHAR_UP_P = 8'h50;
    localparam logic [7:0] CHAR_LO_P = 8'h70;
    localparam logic [7:0] CHAR_UP_R = 8'h52;
    localparam logic [7:0] CHAR_LO_R = 8'h72;

    localparam logic [7:0] DEFAULT_VELOCITY = 8'd127;
    localparam logic [7:0] DEFAULT_CHANNEL = 8'd0;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Multiplies the running value by ten and adds one digit, modulo 256.
    function automatic logic [7:0] add_digit(input logic [7:0] sum, input logic [7:0] c);
        return {sum[4:0], 3'b000} + {sum[6:0], 1'b0} + {4'b0000, c[3:0]};
    endfunction

    function automatic logic [7:0] negate(input logic [7:0] v);
        return 8'd0 - v;
    endfunction

endpackage

// ===== hdl/midi_command_line_parser_core.sv =====
// Command line parser: turns a byte stream of note commands into one decoded result per line.
//
// The input channel (in_valid, in_stall, text_byte, line_end) carries one character per
// transaction; line_end marks the last character of a line. The output channel (out_valid,
// out_stall, key flags, note, velocity, channel) carries one transaction per line.
// An accepted byte is held in an input register; from there the per-character decode runs
// and, for the last byte, loads the result register. A result thus passes through the input
// register and then the result register, with the single decode stage between the two.
// Throughput is one byte per cycle while in_stall is low, set by that decode stage.
// While a result waits under out_stall, bytes that do not end a line keep flowing; only a
// second line end holds the input register, which raises in_stall until the result is taken.
// Reset clears the line state and both valid flags, so the first byte after reset starts a
// new line.
`include "midi_command_line_parser_core_macros.svh"

module midi_command_line_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_midi,
    output logic       is_transit,
    output logic       is_numpad,
    output logic       press,
    output logic       release_res,
    output logic [7:0] note,
    output logic [7:0] velocity,
    output logic [7:0] channel
);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_KEY,
        PH_VALUE
    } line_phase_t;

    typedef enum logic [1:0] {
        NUM_WS,
        NUM_DIGITS,
        NUM_DONE
    } number_phase_t;

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_last_reg;

    line_phase_t   line_phase_reg, line_phase_next;
    logic [1:0]    key_count_reg, key_count_next;
    logic [7:0]    key_first_reg, key_first_next;
    logic [7:0]    key_second_reg, key_second_next;
    logic [1:0]    comma_count_reg, comma_count_next;
    number_phase_t number_phase_reg, number_phase_next;
    logic          number_negative_reg, number_negative_next;
    logic [7:0]    note_sum_reg, note_sum_next;
    logic [7:0]    velocity_sum_reg, velocity_sum_next;
    logic [7:0]    channel_sum_reg, channel_sum_next;

    logic          out_valid_reg;
    logic          is_midi_reg, is_midi_next;
    logic          is_transit_reg, is_transit_next;
    logic          is_numpad_reg, is_numpad_next;
    logic          press_reg, press_next;
    logic          release_reg, release_next;
    logic [7:0]    note_reg, note_next;
    logic [7:0]    velocity_reg, velocity_next;
    logic [7:0]    channel_reg, channel_next;

    logic          advance;
    logic          in_accept;
    logic          out_take;

    assign out_take  = out_valid_reg && !out_stall;
    assign advance   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        line_phase_t   lp;
        number_phase_t np;
        logic [7:0]    c;
        logic [7:0]    cur;
        logic [7:0]    upd;
        logic [7:0]    fin;
        logic          has1;
        logic          has2;
        logic          pr;
        logic          rl;

        c  = s1_byte_reg;
        np = number_phase_reg;

        line_phase_next      = line_phase_reg;
        key_count_next       = key_count_reg;
        key_first_next       = key_first_reg;
        key_second_next      = key_second_reg;
        comma_count_next     = comma_count_reg;
        number_phase_next    = number_phase_reg;
        number_negative_next = number_negative_reg;
        note_sum_next        = note_sum_reg;
        velocity_sum_next    = velocity_sum_reg;
        channel_sum_next     = channel_sum_reg;

        case (comma_count_reg)
            2'd0:    cur = note_sum_reg;
            2'd1:    cur = velocity_sum_reg;
            default: cur = channel_sum_reg;
        endcase
        upd = cur;

        lp = line_phase_reg;
        if ((lp == PH_LEAD) && (c != mclp_pkg::CHAR_SPACE))
        begin
            lp = PH_KEY;
        end
        line_phase_next = lp;

        if (lp == PH_KEY)
        begin
            if (c == mclp_pkg::CHAR_COLON)
            begin
                line_phase_next = PH_VALUE;
            end
            else if (key_count_reg == 2'd0)
            begin
                key_first_next = c;
                key_count_next = 2'd1;
            end
            else if (key_count_reg == 2'd1)
            begin
                key_second_next = c;
                key_count_next  = 2'd2;
            end
        end
        else if (lp == PH_VALUE)
        begin
            if (c == mclp_pkg::CHAR_COMMA)
            begin
                upd                  = number_negative_reg ? mclp_pkg::negate(cur) : cur;
                number_phase_next    = NUM_WS;
                number_negative_next = 1'b0;
            end
            else
            begin
                if (np == NUM_WS)
                begin
                    if (mclp_pkg::is_ws(c))
                    begin
                        np = NUM_WS;
                    end
                    else if ((c == mclp_pkg::CHAR_PLUS) || (c == mclp_pkg::CHAR_MINUS))
                    begin
                        number_negative_next = (c == mclp_pkg::CHAR_MINUS);
                        number_phase_next    = NUM_DIGITS;
                    end
                    else
                    begin
                        np                = NUM_DIGITS;
                        number_phase_next = NUM_DIGITS;
                        if (mclp_pkg::is_digit(c))
                        begin
                            upd = mclp_pkg::add_digit(cur, c);
                        end
                        else
                        begin
                            number_phase_next = NUM_DONE;
                        end
                    end
                end
                else if (np == NUM_DIGITS)
                begin
                    if (mclp_pkg::is_digit(c))
                    begin
                        upd = mclp_pkg::add_digit(cur, c);
                    end
                    else
                    begin
                        number_phase_next = NUM_DONE;
                    end
                end
            end

            case (comma_count_reg)
                2'd0:    note_sum_next = upd;
                2'd1:    velocity_sum_next = upd;
                default: channel_sum_next = upd;
            endcase

            if (c == mclp_pkg::CHAR_COMMA)
            begin
                if (comma_count_reg < 2'd2)
                begin
                    comma_count_next = comma_count_reg + 2'd1;
                end
                else
                begin
                    channel_sum_next = 8'd0;
                end
            end
        end

        // The last byte closes the open field and builds the result.
        case (comma_count_next)
            2'd0:    fin = note_sum_next;
            2'd1:    fin = velocity_sum_next;
            default: fin = channel_sum_next;
        endcase
        if (number_negative_next)
        begin
            fin = mclp_pkg::negate(fin);
        end

        has1 = (key_count_next != 2'd0);
        has2 = (key_count_next == 2'd2);
        is_midi_next = has1 && ((key_first_next == mclp_pkg::CHAR_UP_M) ||
                                (key_first_next == mclp_pkg::CHAR_LO_M));
        is_transit_next = has1 && ((key_first_next == mclp_pkg::CHAR_UP_T) ||
                                   (key_first_next == mclp_pkg::CHAR_LO_T));
        is_numpad_next = has2 &&
            (((key_first_next == mclp_pkg::CHAR_UP_N) &&
              (key_second_next == mclp_pkg::CHAR_UP_P)) ||
             ((key_first_next == mclp_pkg::CHAR_LO_N) &&
              (key_second_next == mclp_pkg::CHAR_LO_P)));
        pr = has2 && ((key_second_next == mclp_pkg::CHAR_UP_P) ||
                      (key_second_next == mclp_pkg::CHAR_LO_P));
        rl = has2 && ((key_second_next == mclp_pkg::CHAR_UP_R) ||
                      (key_second_next == mclp_pkg::CHAR_LO_R));
        press_next   = pr || !rl;
        release_next = rl || !pr;

        note_next     = (comma_count_next == 2'd0) ? fin : note_sum_next;
        velocity_next = (comma_count_next == 2'd0) ? mclp_pkg::DEFAULT_VELOCITY :
                        (comma_count_next == 2'd1) ? fin : velocity_sum_next;
        channel_next  = (comma_count_next == 2'd2) ? fin : mclp_pkg::DEFAULT_CHANNEL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            s1_byte_reg         <= 8'd0;
            s1_last_reg         <= 1'b0;
            line_phase_reg      <= PH_LEAD;
            key_count_reg       <= 2'd0;
            key_first_reg       <= 8'd0;
            key_second_reg      <= 8'd0;
            comma_count_reg     <= 2'd0;
            number_phase_reg    <= NUM_WS;
            number_negative_reg <= 1'b0;
            note_sum_reg        <= 8'd0;
            velocity_sum_reg    <= 8'd0;
            channel_sum_reg     <= 8'd0;
            out_valid_reg       <= 1'b0;
            is_midi_reg         <= 1'b0;
            is_transit_reg      <= 1'b0;
            is_numpad_reg       <= 1'b0;
            press_reg           <= 1'b0;
            release_reg         <= 1'b0;
            note_reg            <= 8'd0;
            velocity_reg        <= 8'd0;
            channel_reg         <= 8'd0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_byte_reg  <= text_byte;
                s1_last_reg  <= line_end;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance && s1_last_reg)
            begin
                line_phase_reg      <= PH_LEAD;
                key_count_reg       <= 2'd0;
                key_first_reg       <= 8'd0;
                key_second_reg      <= 8'd0;
                comma_count_reg     <= 2'd0;
                number_phase_reg    <= NUM_WS;
                number_negative_reg <= 1'b0;
                note_sum_reg        <= 8'd0;
                velocity_sum_reg    <= 8'd0;
                channel_sum_reg     <= 8'd0;
                out_valid_reg       <= 1'b1;
                is_midi_reg         <= is_midi_next;
                is_transit_reg      <= is_transit_next;
                is_numpad_reg       <= is_numpad_next;
                press_reg           <= press_next;
                release_reg         <= release_next;
                note_reg            <= note_next;
                velocity_reg        <= velocity_next;
                channel_reg         <= channel_next;
            end
            else
            begin
                if (advance)
                begin
                    line_phase_reg      <= line_phase_next;
                    key_count_reg       <= key_count_next;
                    key_first_reg       <= key_first_next;
                    key_second_reg      <= key_second_next;
                    comma_count_reg     <= comma_count_next;
                    number_phase_reg    <= number_phase_next;
                    number_negative_reg <= number_negative_next;
                    note_sum_reg        <= note_sum_next;
                    velocity_sum_reg    <= velocity_sum_next;
                    channel_sum_reg     <= channel_sum_next;
                end
                if (out_take)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_midi     = is_midi_reg;
    assign is_transit  = is_transit_reg;
    assign is_numpad   = is_numpad_reg;
    assign press       = press_reg;
    assign release_res = release_reg;
    assign note        = note_reg;
    assign velocity    = velocity_reg;
    assign channel     = channel_reg;

    `MCLP_ASSERT_NEXT(a_line_restart, advance && s1_last_reg,
        (line_phase_reg == PH_LEAD) && (key_count_reg == 2'd0) &&
        (comma_count_reg == 2'd0) && out_valid_reg,
        "Line state not cleared after a line end.")
    `MCLP_ASSERT_SAME(a_stall_cause, in_stall,
        s1_valid_reg && s1_last_reg && out_valid_reg && out_stall,
        "Input stalled without a blocked line end.")
    `MCLP_ASSERT_SAME(a_result_flags, out_valid_reg,
        (press_reg || release_reg) && !(is_numpad_reg && (is_midi_reg || is_transit_reg)),
        "Inconsistent key flags in the result.")

endmodule

// ===== tb/midi_command_line_parser_core_checker.sv =====
// Checker for the command line parser: predicts each decoded line and compares the results.
`timescale 1ns / 1ps

module midi_command_line_parser_core_checker
    import mclp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       line_end,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       is_midi,
    input  logic       is_transit,
    input  logic       is_numpad,
    input  logic       press,
    input  logic       release_res,
    input  logic [7:0] note,
    input  logic [7:0] velocity,
    input  logic [7:0] channel,
    output int         fail_count,
    output int         lines_pending
);

    typedef enum logic [1:0] {LINE_LEAD, LINE_KEY, LINE_VALUE} line_phase_t;
    typedef enum logic [1:0] {NUM_SKIP_WS, NUM_DIGITS, NUM_DONE} num_phase_t;

    typedef struct packed {
        logic       midi;
        logic       transit;
        logic       numpad;
        logic       press;
        logic       rel_flag;
        logic [7:0] note;
        logic [7:0] velocity;
        logic [7:0] channel;
    } line_result_t;

    line_phase_t  lphase;
    num_phase_t   nphase;
    logic [1:0]   key_len;
    logic [7:0]   key_c0;
    logic [7:0]   key_c1;
    logic [1:0]   commas;
    logic         neg;
    logic [7:0]   field_acc [0:2];
    line_result_t decoded_lines [$];
    int           lines_seen;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    task automatic clear_line();
        lphase = LINE_LEAD;
        nphase = NUM_SKIP_WS;
        key_len = 2'd0;
        key_c0 = 8'd0;
        key_c1 = 8'd0;
        commas = 2'd0;
        neg = 1'b0;
        field_acc[0] = 8'd0;
        field_acc[1] = 8'd0;
        field_acc[2] = 8'd0;
    endtask

    task automatic close_field();
        if (neg)
        begin
            field_acc[commas] = 8'd0 - field_acc[commas];
        end
        nphase = NUM_SKIP_WS;
        neg = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch on line %0d: %s", $time, lines_seen, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        line_result_t r;
        logic         consumed;
        consumed = 1'b0;
        if (lphase == LINE_LEAD && c != CHAR_SPACE)
        begin
            lphase = LINE_KEY;
        end
        if (lphase == LINE_KEY)
        begin
            if (c == CHAR_COLON)
            begin
                lphase = LINE_VALUE;
            end
            else if (key_len == 2'd0)
            begin
                key_c0 = c;
                key_len = 2'd1;
            end
            else if (key_len == 2'd1)
            begin
                key_c1 = c;
                key_len = 2'd2;
            end
        end
        else if (lphase == LINE_VALUE)
        begin
            if (c == CHAR_COMMA)
            begin
                close_field();
                if (commas < 2'd2)
                begin
                    commas++;
                end
                else
                begin
                    field_acc[2] = 8'd0;
                end
            end
            else
            begin
                if (nphase == NUM_SKIP_WS && !is_blank(c))
                begin
                    nphase = NUM_DIGITS;
                    consumed = (c == CHAR_PLUS) || (c == CHAR_MINUS);
                    neg = (c == CHAR_MINUS);
                end
                if (nphase == NUM_DIGITS && !consumed)
                begin
                    if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    begin
                        field_acc[commas] = field_acc[commas] * 8'd10 + (c - CHAR_ZERO);
                    end
                    else
                    begin
                        nphase = NUM_DONE;
                    end
                end
            end
        end
        if (last)
        begin
            close_field();
            r.midi = (key_len >= 2'd1) && (key_c0 == CHAR_UP_M || key_c0 == CHAR_LO_M);
            r.transit = (key_len >= 2'd1) && (key_c0 == CHAR_UP_T || key_c0 == CHAR_LO_T);
            r.numpad = (key_len == 2'd2) &&
                       ((key_c0 == CHAR_UP_N && key_c1 == CHAR_UP_P) ||
                        (key_c0 == CHAR_LO_N && key_c1 == CHAR_LO_P));
            r.press = (key_len == 2'd2) && (key_c1 == CHAR_UP_P || key_c1 == CHAR_LO_P);
            r.rel_flag = (key_len == 2'd2) && (key_c1 == CHAR_UP_R || key_c1 == CHAR_LO_R);
            if (!r.press && !r.rel_flag)
            begin
                r.press = 1'b1;
                r.rel_flag = 1'b1;
            end
            r.note = field_acc[0];
            r.velocity = (commas >= 2'd1) ? field_acc[1] : DEFAULT_VELOCITY;
            r.channel = (commas >= 2'd2) ? field_acc[2] : DEFAULT_CHANNEL;
            decoded_lines.push_back(r);
            clear_line();
        end
    endtask

    task automatic check_result();
        line_result_t want;
        if (decoded_lines.size() == 0)
        begin
            report_mismatch("result with no line pending");
        end
        else
        begin
            want = decoded_lines.pop_front();
            check_field("is_midi", is_midi, want.midi);
            check_field("is_transit", is_transit, want.transit);
            check_field("is_numpad", is_numpad, want.numpad);
            check_field("press", press, want.press);
            check_field("release_res", release_res, want.rel_flag);
            check_field("note", note, want.note);
            check_field("velocity", velocity, want.velocity);
            check_field("channel", channel, want.channel);
        end
        lines_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            decoded_lines.delete();
            fail_count = 0;
            lines_seen = 0;
            lines_pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (in_valid && !in_stall)
            begin
                decode_char(text_byte, line_end);
            end
            lines_pending = decoded_lines.size();
        end
    end

endmodule

// ===== tb/tb_midi_command_line_parser_core.sv =====
// Testbench top for the command line parser: clock, reset, line stimulus and the verdict.
`timescale 1ns / 1ps

module tb_midi_command_line_parser_core;
    import mclp_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] text_byte;
    logic       line_end;
    logic       out_valid;
    logic       out_stall;
    logic       is_midi;
    logic       is_transit;
    logic       is_numpad;
    logic       press;
    logic       release_res;
    logic [7:0] note;
    logic [7:0] velocity;
    logic [7:0] channel;

    int fail_count;
    int lines_pending;
    int bytes_sent;
    bit quiet;
    bit hold_request;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    midi_command_line_parser_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_midi    (is_midi),
        .is_transit (is_transit),
        .is_numpad  (is_numpad),
        .press      (press),
        .release_res(release_res),
        .note       (note),
        .velocity   (velocity),
        .channel    (channel)
    );

    midi_command_line_parser_core_checker line_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .line_end     (line_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_midi      (is_midi),
        .is_transit   (is_transit),
        .is_numpad    (is_numpad),
        .press        (press),
        .release_res  (release_res),
        .note         (note),
        .velocity     (velocity),
        .channel      (channel),
        .fail_count   (fail_count),
        .lines_pending(lines_pending)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic byte_q_t to_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
        begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic byte_q_t random_line();
        byte_q_t q;
        string   key_chars;
        string   junk_chars;
        int      n_fields;
        key_chars = "MmTtNnPpRrX9 ,";
        junk_chars = " x:+-.";
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) q.push_back(CHAR_SPACE);
            repeat ($urandom_range(0, 3))
            begin
                q.push_back(key_chars[$urandom_range(0, key_chars.len() - 1)]);
            end
            if ($urandom_range(0, 9) != 0)
            begin
                q.push_back(CHAR_COLON);
                n_fields = $urandom_range(1, 5);
                for (int k = 0; k < n_fields; k++)
                begin
                    if (k > 0)
                    begin
                        q.push_back(CHAR_COMMA);
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        q.push_back(($urandom_range(0, 1) == 0) ? CHAR_SPACE :
                                    8'($urandom_range(9, 13)));
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        q.push_back(($urandom_range(0, 1) == 0) ? CHAR_PLUS : CHAR_MINUS);
                    end
                    repeat ($urandom_range(0, 4)) q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                    if ($urandom_range(0, 7) == 0)
                    begin
                        q.push_back(junk_chars[$urandom_range(0, junk_chars.len() - 1)]);
                    end
                end
            end
            if (q.size() == 0)
            begin
                q.push_back(CHAR_SPACE);
            end
        end
        return q;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last);
        int   gap;
        logic took;
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= c;
        line_end <= last;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        bytes_sent++;
    endtask

    task automatic send_line(input byte_q_t q);
        for (int i = 0; i < q.size(); i++)
        begin
            send_byte(q[i], i == q.size() - 1);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (lines_pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        byte_q_t line;
        bit      hold_done;
        bit      drain_done;
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_byte = 8'd0;
        line_end = 1'b0;
        quiet = 1'b0;
        hold_request = 1'b0;
        bytes_sent = 0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_line(to_bytes(" "));
        send_line(to_bytes("t"));
        send_line(to_bytes("np:9,,7,5"));
        send_line(to_bytes("Np:-"));
        line = to_bytes("MR,:x,999");
        line[4] = 8'hFF;
        send_line(line);
        line = '{8'h00};
        send_line(line);

        while (bytes_sent < 1150)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                quiet = !quiet;
            end
            if (!hold_done && bytes_sent >= 350)
            begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && bytes_sent >= 750)
            begin
                wait_for_results();
                drain_done = 1'b1;
            end
            send_line(random_line());
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** midi_command_line_parser_core: PASSED **");
        end
        else
        begin
            $display("** midi_command_line_parser_core: FAILED **");
        end
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("** midi_command_line_parser_core: FAILED **");
        $finish;
    end

endmodule

// ===== midi_command_line_parser_core.f =====
+incdir+hdl
hdl/mclp_pkg.sv
hdl/midi_command_line_parser_core.sv
tb/midi_command_line_parser_core_checker.sv
tb/tb_midi_command_line_parser_core.sv
